>>> rtl/core/iexu_pkg.sv
// ----------------------------------------------------------------------------
// iexu_pkg
// Shared opcodes, sizes and controller/datapath command and status types for
// the integer execute unit.
// ----------------------------------------------------------------------------
package iexu_pkg;

  localparam int REG_COUNT = 64;
  localparam int REG_AW    = 6;
  localparam int XLEN      = 64;
  localparam int HALF      = XLEN / 2;

  localparam logic [5:0] OP_ASSIGN  = 6'd0;
  localparam logic [5:0] OP_NOT     = 6'd1;
  localparam logic [5:0] OP_INV     = 6'd2;
  localparam logic [5:0] OP_SHL     = 6'd3;
  localparam logic [5:0] OP_SHR     = 6'd4;
  localparam logic [5:0] OP_LAND    = 6'd5;
  localparam logic [5:0] OP_BAND    = 6'd6;
  localparam logic [5:0] OP_LOR     = 6'd7;
  localparam logic [5:0] OP_BOR     = 6'd8;
  localparam logic [5:0] OP_XOR     = 6'd9;
  localparam logic [5:0] OP_ADD     = 6'd10;
  localparam logic [5:0] OP_SUB     = 6'd11;
  localparam logic [5:0] OP_MUL     = 6'd12;
  localparam logic [5:0] OP_SDIV    = 6'd13;
  localparam logic [5:0] OP_UDIV    = 6'd14;
  localparam logic [5:0] OP_SMOD    = 6'd15;
  localparam logic [5:0] OP_UMOD    = 6'd16;
  localparam logic [5:0] OP_NEG     = 6'd17;
  localparam logic [5:0] OP_INC     = 6'd18;
  localparam logic [5:0] OP_DEC     = 6'd19;
  localparam logic [5:0] OP_SLT     = 6'd20;
  localparam logic [5:0] OP_ULT     = 6'd21;
  localparam logic [5:0] OP_SLE     = 6'd22;
  localparam logic [5:0] OP_ULE     = 6'd23;
  localparam logic [5:0] OP_SGT     = 6'd24;
  localparam logic [5:0] OP_UGT     = 6'd25;
  localparam logic [5:0] OP_SGE     = 6'd26;
  localparam logic [5:0] OP_UGE     = 6'd27;
  localparam logic [5:0] OP_EQ      = 6'd28;
  localparam logic [5:0] OP_NE      = 6'd29;
  localparam logic [5:0] OP_BRANCH  = 6'd30;
  localparam logic [5:0] OP_JUMP    = 6'd31;
  localparam logic [5:0] OP_CONVERT = 6'd32;

  // Partial product select for the shared 32x32 multiplier
  localparam logic [1:0] MSEL_LL = 2'd0;
  localparam logic [1:0] MSEL_LH = 2'd1;
  localparam logic [1:0] MSEL_HL = 2'd2;

  typedef struct packed {
    logic       capture;
    logic       rd_cur;
    logic [1:0] mul_sel;
    logic       acc_load;
    logic       acc_add;
    logic       div_start;
    logic       finish;
  } cmd_t;

  typedef struct packed {
    logic is_mul;
    logic is_div;
    logic div_done;
  } status_t;

endpackage

>>> rtl/core/iexu_div.sv
// ----------------------------------------------------------------------------
// iexu_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module iexu_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [63:0] divisor,
  output logic [63:0] quot,
  output logic [63:0] rem,
  output logic        done
);
  import iexu_pkg::*;

  logic [XLEN-1:0] rem_r, quo_r, div_r;
  logic [5:0]      cnt_r;
  logic            busy_r, done_r;
  logic [XLEN:0]   trial, diff;
  logic            ge;

  // Shift in next dividend bit and try to subtract
  assign trial = {rem_r, quo_r[XLEN-1]};
  assign diff  = trial - {1'b0, div_r};
  assign ge    = trial >= {1'b0, div_r};

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      div_r <= divisor;
      cnt_r <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? diff[XLEN-1:0] : trial[XLEN-1:0];
      quo_r <= {quo_r[XLEN-2:0], ge};
      cnt_r <= cnt_r + 6'd1;
    end
  end

  // Track busy and done
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
    end else if (busy_r && cnt_r == 6'd63) begin
      busy_r <= 1'b0;
      done_r <= 1'b1;
    end
  end

  assign quot = quo_r;
  assign rem  = rem_r;
  assign done = done_r;

endmodule

>>> rtl/core/iexu_dp.sv
// ----------------------------------------------------------------------------
// iexu_dp
// Datapath: register file memory, instruction capture, ALU, multiplier
// accumulation, divider and result register.
// ----------------------------------------------------------------------------
module iexu_dp (
  input  logic             clk,
  input  logic             rst_n,
  input  iexu_pkg::cmd_t   cmd,
  output iexu_pkg::status_t status,
  input  logic [5:0]       in_opcode,
  input  logic [5:0]       in_dest_reg,
  input  logic             in_first_is_imm,
  input  logic [5:0]       in_first_reg,
  input  logic [63:0]      in_first_imm,
  input  logic             in_second_is_imm,
  input  logic [5:0]       in_second_reg,
  input  logic [63:0]      in_second_imm,
  input  logic [1:0]       in_conv_dest_size,
  input  logic [1:0]       in_conv_src_size,
  input  logic             in_conv_src_signed,
  output logic             out_wrote,
  output logic [5:0]       out_write_reg,
  output logic [63:0]      out_write_value,
  output logic             out_redirect,
  output logic [15:0]      out_target_label
);
  import iexu_pkg::*;

  logic [XLEN-1:0] mem [REG_COUNT];
  logic [REG_COUNT-1:0] vld_r;

  logic [5:0]      op_r, dst_r, fr_r, sr_r;
  logic            fimm_r, simm_r, csgn_r;
  logic [XLEN-1:0] fval_r, sval_r;
  logic [1:0]      cdst_r, csrc_r;
  logic [XLEN-1:0] rda_r, rdb_r, rdc_r;
  logic            va_r, vb_r, vc_r;

  logic [XLEN-1:0] a, b, cur, val, sm, dm, cs;
  logic            wr, redir, sgn_op, dst_ok;
  logic [XLEN-1:0] ua, ub, q, r, prod_r, acc_r;
  logic [HALF-1:0] ma, mb;
  logic            ddone;

  function automatic logic in_rng(input logic [5:0] idx);
    return {1'b0, idx} < 7'(REG_COUNT);
  endfunction

  function automatic logic [XLEN-1:0] wmask(input logic [1:0] sz);
    logic [XLEN-1:0] m;
    unique case (sz)
      2'd0:    m = 64'h0000_0000_0000_00FF;
      2'd1:    m = 64'h0000_0000_0000_FFFF;
      2'd2:    m = 64'h0000_0000_FFFF_FFFF;
      default: m = '1;
    endcase
    return m;
  endfunction

  // Capture the instruction on accept
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r   <= in_opcode;
      dst_r  <= in_dest_reg;
      fimm_r <= in_first_is_imm;
      fr_r   <= in_first_reg;
      fval_r <= in_first_imm;
      simm_r <= in_second_is_imm;
      sr_r   <= in_second_reg;
      sval_r <= in_second_imm;
      cdst_r <= in_conv_dest_size;
      csrc_r <= in_conv_src_size;
      csgn_r <= in_conv_src_signed;
    end
  end

  // Register file: read sources on accept, destination in the following cycle
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      rda_r <= mem[in_first_reg[REG_AW-1:0]];
      rdb_r <= mem[in_second_reg[REG_AW-1:0]];
    end
    if (cmd.rd_cur) begin
      rdc_r <= mem[dst_r[REG_AW-1:0]];
    end
    if (cmd.finish && wr) begin
      mem[dst_r[REG_AW-1:0]] <= val;
    end
  end

  // Written flags, cleared on reset; unwritten entries read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      va_r  <= 1'b0;
      vb_r  <= 1'b0;
      vc_r  <= 1'b0;
    end else begin
      if (cmd.capture) begin
        va_r <= in_rng(in_first_reg) && vld_r[in_first_reg[REG_AW-1:0]];
        vb_r <= in_rng(in_second_reg) && vld_r[in_second_reg[REG_AW-1:0]];
      end
      if (cmd.rd_cur) begin
        vc_r <= in_rng(dst_r) && vld_r[dst_r[REG_AW-1:0]];
      end
      if (cmd.finish && wr) begin
        vld_r[dst_r[REG_AW-1:0]] <= 1'b1;
      end
    end
  end

  assign a   = fimm_r ? fval_r : (va_r ? rda_r : '0);
  assign b   = simm_r ? sval_r : (vb_r ? rdb_r : '0);
  assign cur = vc_r ? rdc_r : '0;

  // Multiply: three 32x32 partial products, accumulated into the low word
  always_comb begin
    unique case (cmd.mul_sel)
      MSEL_LL: begin ma = a[HALF-1:0];    mb = b[HALF-1:0];    end
      MSEL_LH: begin ma = a[HALF-1:0];    mb = b[XLEN-1:HALF]; end
      MSEL_HL: begin ma = a[XLEN-1:HALF]; mb = b[HALF-1:0];    end
      default: begin ma = '0;             mb = '0;             end
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= ma * mb;
    if (cmd.acc_load) begin
      acc_r <= prod_r;
    end else if (cmd.acc_add) begin
      acc_r <= acc_r + {prod_r[HALF-1:0], {HALF{1'b0}}};
    end
  end

  // Divide on magnitudes; signs fixed up on the way out
  assign sgn_op = (op_r == OP_SDIV) || (op_r == OP_SMOD);
  assign ua = (sgn_op && a[XLEN-1]) ? -a : a;
  assign ub = (sgn_op && b[XLEN-1]) ? -b : b;

  iexu_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (ua),
    .divisor  (ub),
    .quot     (q),
    .rem      (r),
    .done     (ddone)
  );

  assign status.is_mul   = (op_r == OP_MUL);
  assign status.is_div   = (op_r == OP_SDIV) || (op_r == OP_UDIV) ||
                           (op_r == OP_SMOD) || (op_r == OP_UMOD);
  assign status.div_done = ddone;

  // Convert masks and extended source
  always_comb begin
    sm = wmask(csrc_r);
    dm = wmask(cdst_r);
    cs = a & sm;
    if (csgn_r && csrc_r != 2'd3 && (cs & (sm ^ (sm >> 1))) != '0) begin
      cs = cs | ~sm;
    end
  end

  // Result select
  always_comb begin
    val   = '0;
    wr    = 1'b1;
    redir = 1'b0;
    unique case (op_r)
      OP_ASSIGN:  val = a;
      OP_NOT:     val = XLEN'(a == '0);
      OP_INV:     val = ~a;
      OP_SHL:     val = (|b[XLEN-1:6]) ? '0 : a << b[5:0];
      OP_SHR:     val = (|b[XLEN-1:6]) ? '0 : a >> b[5:0];
      OP_LAND:    val = XLEN'((a != '0) && (b != '0));
      OP_BAND:    val = a & b;
      OP_LOR:     val = XLEN'((a != '0) || (b != '0));
      OP_BOR:     val = a | b;
      OP_XOR:     val = a ^ b;
      OP_ADD:     val = a + b;
      OP_SUB:     val = a - b;
      OP_MUL:     val = acc_r;
      OP_SDIV:    val = (b == '0) ? '1 : ((a[XLEN-1] ^ b[XLEN-1]) ? -q : q);
      OP_UDIV:    val = (b == '0) ? '1 : q;
      OP_SMOD:    val = (b == '0) ? a : (a[XLEN-1] ? -r : r);
      OP_UMOD:    val = (b == '0) ? a : r;
      OP_NEG:     val = -cur;
      OP_INC:     val = cur + 64'd1;
      OP_DEC:     val = cur - 64'd1;
      OP_SLT:     val = XLEN'($signed(a) <  $signed(b));
      OP_ULT:     val = XLEN'(a <  b);
      OP_SLE:     val = XLEN'($signed(a) <= $signed(b));
      OP_ULE:     val = XLEN'(a <= b);
      OP_SGT:     val = XLEN'($signed(a) >  $signed(b));
      OP_UGT:     val = XLEN'(a >  b);
      OP_SGE:     val = XLEN'($signed(a) >= $signed(b));
      OP_UGE:     val = XLEN'(a >= b);
      OP_EQ:      val = XLEN'(a == b);
      OP_NE:      val = XLEN'(a != b);
      OP_BRANCH:  begin wr = 1'b0; redir = (cur == '0); end
      OP_JUMP:    begin wr = 1'b0; redir = 1'b1; end
      OP_CONVERT: val = (cur & ~dm) | (cs & dm);
      default:    wr = 1'b0;
    endcase
    dst_ok = in_rng(dst_r);
    wr     = wr && dst_ok;
  end

  // Load the result register
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_wrote        <= wr;
      out_write_reg    <= wr ? dst_r : '0;
      out_write_value  <= wr ? val : '0;
      out_redirect     <= redir;
      out_target_label <= redir ? fval_r[15:0] : '0;
    end
  end

endmodule

>>> rtl/core/iexu_ctrl.sv
// ----------------------------------------------------------------------------
// iexu_ctrl
// Controller: sequences register reads, multiply steps, divide wait and the
// result hand-off.
// ----------------------------------------------------------------------------
module iexu_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  iexu_pkg::status_t  status,
  output iexu_pkg::cmd_t     cmd
);
  import iexu_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RDC  = 3'd1;
  localparam logic [2:0] S_MUL0 = 3'd2;
  localparam logic [2:0] S_MUL1 = 3'd3;
  localparam logic [2:0] S_MUL2 = 3'd4;
  localparam logic [2:0] S_MUL3 = 3'd5;
  localparam logic [2:0] S_DIVW = 3'd6;
  localparam logic [2:0] S_FIN  = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic       ovld_r, ovld_nxt;
  logic       free;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = ovld_r;
  assign free      = !ovld_r || !out_stall;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    ovld_nxt  = ovld_r && out_stall;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        cmd.capture = in_valid;
        if (in_valid) state_nxt = S_RDC;
      end
      S_RDC: begin
        cmd.rd_cur = 1'b1;
        if (status.is_mul) begin
          state_nxt = S_MUL0;
        end else if (status.is_div) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIVW;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_MUL0: begin
        cmd.mul_sel = MSEL_LL;
        state_nxt   = S_MUL1;
      end
      S_MUL1: begin
        cmd.mul_sel  = MSEL_LH;
        cmd.acc_load = 1'b1;
        state_nxt    = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul_sel = MSEL_HL;
        cmd.acc_add = 1'b1;
        state_nxt   = S_MUL3;
      end
      S_MUL3: begin
        cmd.acc_add = 1'b1;
        state_nxt   = S_FIN;
      end
      S_DIVW: begin
        if (status.div_done) state_nxt = S_FIN;
      end
      S_FIN: begin
        if (free) begin
          cmd.finish = 1'b1;
          ovld_nxt   = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ovld_r  <= ovld_nxt;
    end
  end

`ifndef SYNTH
  a_accept_reads : assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_RDC))
    else $error("accepted request did not start register read");

  a_result_from_fin : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> ($past(state_r) == S_FIN))
    else $error("result shown without finish step");

  a_fin_hands_off : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && free) |=> (state_r == S_IDLE && out_valid))
    else $error("finish step did not load the result");
`endif

endmodule

>>> rtl/core/ir_integer_execute_unit.sv
// ----------------------------------------------------------------------------
// ir_integer_execute_unit
// Executes one integer intermediate-code instruction per request against a
// 64 x 64-bit register file.
//
//   channel | direction | handshake            | payload
//   in_     | input     | in_valid / in_stall  | instruction fields
//   out_    | output    | out_valid / out_stall| write and redirect report
//
// Simple operations pass from accept through source read, dest read and
// finish. Multiply adds the multiply steps, using one 32x32 multiplier over
// three partial products. Divide and modulo wait on the radix-2 divider.
// Reset clears the register file through per-entry written flags, with no
// clearing pass. A stalled result holds the finish step.
// ----------------------------------------------------------------------------
module ir_integer_execute_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [5:0]  in_opcode,
  input  logic [5:0]  in_dest_reg,
  input  logic        in_first_is_imm,
  input  logic [5:0]  in_first_reg,
  input  logic [63:0] in_first_imm,
  input  logic        in_second_is_imm,
  input  logic [5:0]  in_second_reg,
  input  logic [63:0] in_second_imm,
  input  logic [1:0]  in_conv_dest_size,
  input  logic [1:0]  in_conv_src_size,
  input  logic        in_conv_src_signed,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_wrote,
  output logic [5:0]  out_write_reg,
  output logic [63:0] out_write_value,
  output logic        out_redirect,
  output logic [15:0] out_target_label
);
  import iexu_pkg::*;

  cmd_t    cmd;
  status_t status;

  iexu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  iexu_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .status             (status),
    .in_opcode          (in_opcode),
    .in_dest_reg        (in_dest_reg),
    .in_first_is_imm    (in_first_is_imm),
    .in_first_reg       (in_first_reg),
    .in_first_imm       (in_first_imm),
    .in_second_is_imm   (in_second_is_imm),
    .in_second_reg      (in_second_reg),
    .in_second_imm      (in_second_imm),
    .in_conv_dest_size  (in_conv_dest_size),
    .in_conv_src_size   (in_conv_src_size),
    .in_conv_src_signed (in_conv_src_signed),
    .out_wrote          (out_wrote),
    .out_write_reg      (out_write_reg),
    .out_write_value    (out_write_value),
    .out_redirect       (out_redirect),
    .out_target_label   (out_target_label)
  );

endmodule
